// ===== sv/ufilt_pkg.sv =====
package ufilt_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} raw_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_last;
		logic       packet_end;
	} clean_item_t;

	// most results one item can cause, and the width of a count of them
	localparam int unsigned MaxResults = 4;
	localparam int unsigned CntW = 3;

	// queue depth must be a power of two and at least MaxResults
	localparam int unsigned QueueDepthDefault = 8;

	typedef struct packed {
		logic            push;
		logic [CntW-1:0] count;
	} push_ctl_t;

	localparam logic [7:0] AsciiMax = 8'h7F;
	localparam logic [7:0] Mask2 = 8'hC0;
	localparam logic [7:0] Mask3 = 8'hE0;
	localparam logic [7:0] Mask4 = 8'hF0;
	localparam logic [7:0] Mask5 = 8'hF8;
	localparam logic [7:0] ContCode = 8'h80;
	localparam logic [7:0] Lead2Code = 8'hC0;
	localparam logic [7:0] Lead3Code = 8'hE0;
	localparam logic [7:0] Lead4Code = 8'hF0;

endpackage

// ===== sv/utf8_sequence_filter.sv =====
// channel  | valid        | stall        | item
// ---------+--------------+--------------+---------------------------
// input    | raw_valid    | raw_stall    | raw_item   (raw_item_t)
// output   | clean_valid  | clean_stall  | clean_item (clean_item_t)
//
// one item per cycle enters the input register while raw_stall is low; it is
// decoded combinationally into the result queue, the first result can leave
// the cycle after that; each result leaves the queue in its own cycle while
// clean_stall is low; input stalls only when the queue lacks room
// reset clears the held sequence, the input register and the queue
module utf8_sequence_filter import ufilt_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        raw_valid,
	output logic        raw_stall,
	input  raw_item_t   raw_item,
	output logic        clean_valid,
	input  logic        clean_stall,
	output clean_item_t clean_item
);

	localparam int unsigned LvlW = $clog2(QUEUE_DEPTH) + 1;

	logic                         valid_s1;
	raw_item_t                    item_s1;
	logic                         advance;
	logic [CntW-1:0]              count;
	clean_item_t [MaxResults-1:0] results;
	logic [LvlW-1:0]              level;
	logic [LvlW-1:0]              free;
	push_ctl_t                    push_ctl;

	assign free = LvlW'(QUEUE_DEPTH) - level;
	assign advance = valid_s1 && (free >= LvlW'(count));
	assign raw_stall = valid_s1 && !advance;
	assign push_ctl.push = advance;
	assign push_ctl.count = count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!raw_stall) begin
			valid_s1 <= raw_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (raw_valid && !raw_stall) begin
			item_s1 <= raw_item;
		end
	end

	ufilt_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_s1 (item_s1),
		.advance (advance),
		.count   (count),
		.results (results)
	);

	ufilt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (push_ctl),
		.wdata      (results),
		.stall      (clean_stall),
		.head       (clean_item),
		.head_valid (clean_valid),
		.level      (level)
	);

`ifndef SYNTHESIS
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= LvlW'(QUEUE_DEPTH))
		else $error("result queue overfilled");

	a_level_track: assert property (@(posedge clk) disable iff (!arst_n)
		level == $past(level) + ($past(advance) ? LvlW'($past(count)) : LvlW'(0))
			- LvlW'($past(clean_valid) && !$past(clean_stall)))
		else $error("result queue level lost an item");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> (LvlW'(count) <= free))
		else $error("push without room");
`endif

endmodule

// ===== sv/ufilt_core.sv =====
module ufilt_core import ufilt_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  raw_item_t                     item_s1,
	input  logic                          advance,
	output logic [CntW-1:0]               count,
	output clean_item_t [MaxResults-1:0]  results
);

	logic [7:0] held_q [3];
	logic [1:0] held_cnt_q;
	logic [1:0] need_q;

	logic [7:0] held_d [3];
	logic [1:0] held_cnt_d;
	logic [1:0] need_d;

	logic [7:0] b;
	logic       cont;
	logic       fresh;
	logic [1:0] need;
	logic [CntW-1:0] n;

	always_comb begin
		b = item_s1.in_byte;
		cont = (b & Mask2) == ContCode;
		results = '0;
		n = '0;
		held_d = held_q;
		held_cnt_d = held_cnt_q;
		need_d = need_q;
		fresh = 1'b1;
		need = 2'd0;

		if (held_cnt_q != 2'd0 && cont) begin
			fresh = 1'b0;
			if (need_q <= 2'd1) begin
				// sequence complete: emit held bytes then this one
				for (int i = 0; i < 3; i++) begin
					if (2'(i) < held_cnt_q) begin
						results[i].out_byte = held_q[i];
						results[i].byte_valid = 1'b1;
					end
				end
				results[held_cnt_q].out_byte = b;
				results[held_cnt_q].byte_valid = 1'b1;
				n = {1'b0, held_cnt_q} + 3'd1;
				held_cnt_d = 2'd0;
				need_d = 2'd0;
			end else begin
				held_d[held_cnt_q] = b;
				held_cnt_d = held_cnt_q + 2'd1;
				need_d = need_q - 2'd1;
			end
		end else if (held_cnt_q != 2'd0) begin
			// broken sequence is dropped
			held_cnt_d = 2'd0;
			need_d = 2'd0;
		end

		if (fresh) begin
			if (b <= AsciiMax) begin
				results[0].out_byte = b;
				results[0].byte_valid = 1'b1;
				n = 3'd1;
			end else if ((b & Mask3) == Lead2Code) begin
				need = 2'd1;
			end else if ((b & Mask4) == Lead3Code) begin
				need = 2'd2;
			end else if ((b & Mask5) == Lead4Code) begin
				need = 2'd3;
			end
			if (need != 2'd0) begin
				held_d[0] = b;
				held_cnt_d = 2'd1;
				need_d = need;
			end
		end

		if (item_s1.in_last) begin
			held_cnt_d = 2'd0;
			need_d = 2'd0;
			// bare end marker
			if (n == 3'd0) begin
				n = 3'd1;
			end
		end

		for (int i = 0; i < MaxResults; i++) begin
			if (n == CntW'(i + 1)) begin
				results[i].run_last = 1'b1;
				results[i].packet_end = item_s1.in_last;
			end
		end
	end

	assign count = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
			need_q <= 2'd0;
		end else if (advance) begin
			held_cnt_q <= held_cnt_d;
			need_q <= need_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			held_q <= held_d;
		end
	end

endmodule

// ===== sv/ufilt_queue.sv =====
module ufilt_queue import ufilt_pkg::*; #(
	parameter int unsigned DEPTH = QueueDepthDefault
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  push_ctl_t                        ctl,
	input  clean_item_t [MaxResults-1:0]     wdata,
	input  logic                             stall,
	output clean_item_t                      head,
	output logic                             head_valid,
	output logic [$clog2(DEPTH):0]           level
);

	localparam int unsigned PtrW = $clog2(DEPTH);
	localparam int unsigned LvlW = PtrW + 1;

	clean_item_t     mem [DEPTH];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [LvlW-1:0] level_q;
	logic            pop;

	assign head_valid = level_q != '0;
	assign head = mem[rd_q];
	assign pop = head_valid && !stall;
	assign level = level_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			for (int k = 0; k < MaxResults; k++) begin
				if (CntW'(k) < ctl.count) begin
					mem[wr_q + PtrW'(k)] <= wdata[k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			level_q <= '0;
		end else begin
			if (ctl.push) begin
				wr_q <= wr_q + PtrW'(ctl.count);
			end
			if (pop) begin
				rd_q <= rd_q + PtrW'(1);
			end
			level_q <= level_q + (ctl.push ? LvlW'(ctl.count) : LvlW'(0)) - LvlW'(pop);
		end
	end

endmodule
